// ===== rtl/mlfq_pkg.sv =====
`default_nettype none
package mlfq_pkg;

  // Fixed-point format and sizes
  localparam int FRAC_BITS   = 14;
  localparam int MAX_THREADS = 64;
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 6;
  localparam int NICE_W      = 6;
  localparam int READY_W     = 7;

  localparam int FIX_ONE  = 1 << FRAC_BITS;
  localparam int K1       = (59 * FIX_ONE) / 60;   // 59/60 in fixed point
  localparam int K2       = FIX_ONE / 60;          // 1/60 in fixed point
  localparam int SCALE100 = 100;

  // Shared multiply unit: DATA_W x MUL_B_W signed, then divide by 2^FRAC_BITS toward zero, add, saturate
  localparam int MUL_B_W = FRAC_BITS + 3;
  localparam int PROD_W  = DATA_W + MUL_B_W;
  localparam int ADD_W   = FRAC_BITS + NICE_W + 1;

  // Divider step counter
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  // Config port
  localparam int ADDR_W = 3;
  localparam int IDX_W  = ADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_MAX_PRIO = '0;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_DECAY = 2'd1,
    MODE_PRIO  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_POST,
    ST_PRIO,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DECAY,
    OP_TICK,
    OP_LX100,
    OP_RX100
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  a;
    logic signed [MUL_B_W-1:0] b;
    logic                      rnd;
    logic signed [ADD_W-1:0]   addend;
  } mac_req_t;

endpackage
`default_nettype wire

// ===== rtl/mlfq_div.sv =====
`default_nettype none
// Restoring divider: quot = floor(num * 2^FRAC_BITS / (num + 2^FRAC_BITS)),
// one quotient bit per cycle. num < den, so the quotient fits FRAC_BITS bits.
module mlfq_div import mlfq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DATA_W-1:0]    num,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DATA_W+1:0]    rem_r;
  logic [DATA_W:0]      den_r;
  logic [FRAC_BITS-1:0] quot_r;

  logic [DATA_W+1:0]    shifted;
  logic                 ge;

  // One shift / compare / subtract step
  always_comb begin
    shifted = {rem_r[DATA_W:0], 1'b0};
    ge      = shifted >= {1'b0, den_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num};
      den_r <= {1'b0, num} + (DATA_W+1)'(FIX_ONE);
    end else if (busy_r) begin
      rem_r  <= ge ? (shifted - {1'b0, den_r}) : shifted;
      quot_r <= {quot_r[FRAC_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// ===== rtl/mlfq_mac.sv =====
`default_nettype none
// Shared arithmetic unit: product registered in the first cycle, then
// optional round-half-away, truncation toward zero by 2^FRAC_BITS,
// addend and 32-bit saturation.
module mlfq_mac import mlfq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     load_en,
  input  wire mac_req_t                 req,
  output logic signed [DATA_W-1:0]      res
);

  localparam int Q_W   = PROD_W - FRAC_BITS + 1;
  localparam int TOT_W = Q_W + 1;
  localparam logic signed [PROD_W:0] HALF = (PROD_W+1)'(FIX_ONE / 2);
  localparam logic signed [PROD_W:0] RMSK = (PROD_W+1)'(FIX_ONE - 1);

  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_r;
  logic                     rnd_r;
  logic signed [ADD_W-1:0]  addend_r;

  logic signed [PROD_W:0]   biased;
  logic signed [PROD_W:0]   adj;
  logic signed [Q_W-1:0]    quo;
  logic signed [TOT_W-1:0]  total;

  assign prod_w = $signed(req.a) * $signed(req.b);

  // Multiply stage
  always_ff @(posedge clk) begin
    if (load_en) begin
      prod_r   <= prod_w;
      rnd_r    <= req.rnd;
      addend_r <= req.addend;
    end
  end

  // Scale, add, saturate
  always_comb begin
    biased = $signed({prod_r[PROD_W-1], prod_r});
    if (rnd_r) begin
      biased = prod_r[PROD_W-1] ? (biased - HALF) : (biased + HALF);
    end
    adj   = biased[PROD_W] ? (biased + RMSK) : biased;
    quo   = adj[PROD_W:FRAC_BITS];
    total = $signed({quo[Q_W-1], quo})
          + $signed({{(TOT_W-ADD_W){addend_r[ADD_W-1]}}, addend_r});
    if (total[TOT_W-1] && !(&total[TOT_W-2:DATA_W-1])) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (!total[TOT_W-1] && (|total[TOT_W-2:DATA_W-1])) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res = total[DATA_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mlfq_priority_calculator_unit.sv =====
`default_nettype none
// Sequence: a load update runs the shared multiplier on the load average; a priority
// first computes the priority, a tick first updates recent, and a decay first runs the
// 14-step divider, then the shared multiplier. All then form load x100 and recent x100.
// Idle threads in decay/priority/tick modes skip straight to the x100 values.
// One item at a time: the next item is taken once the result is in the output register.
// Reset: load average 0, max_priority 63, output empty; no memory to clear.
module mlfq_priority_calculator_unit import mlfq_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_mode,
  input  wire logic signed [DATA_W-1:0]  in_recent_cpu_in,
  input  wire logic signed [NICE_W-1:0]  in_nice_value,
  input  wire logic [READY_W-1:0]        in_ready_count,
  input  wire logic                      in_is_idle,

  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [DATA_W-1:0]       out_recent_cpu_out,
  output logic [PRIO_W-1:0]              out_priority_out,
  output logic signed [DATA_W-1:0]       out_load_x100,
  output logic signed [DATA_W-1:0]       out_recent_x100,

  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]              prdata,
  output logic                           pready
);

  localparam int PV_W = DATA_W + 4;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic                      out_valid_r;
  logic [PRIO_W-1:0]         max_prio_r;
  logic signed [DATA_W-1:0]  load_r;

  logic signed [DATA_W-1:0]  recent_r;
  logic signed [NICE_W-1:0]  nice_r;
  logic [READY_W-1:0]        ready_r;
  logic [PRIO_W-1:0]         prio_r;
  logic signed [DATA_W-1:0]  rx100_r;
  logic signed [DATA_W-1:0]  lx100_r;

  logic signed [DATA_W-1:0]  out_recent_r;
  logic [PRIO_W-1:0]         out_prio_r;
  logic signed [DATA_W-1:0]  out_lx100_r;
  logic signed [DATA_W-1:0]  out_rx100_r;

  logic                      in_acc;
  logic                      out_load;
  logic                      cfg_wr;
  logic [IDX_W-1:0]          reg_idx;
  logic [READY_W-1:0]        ready_eff;

  logic                      div_start;
  logic                      div_done;
  logic [FRAC_BITS-1:0]      div_quot;
  logic [DATA_W-1:0]         div_num;

  mac_req_t                  mac_req;
  logic                      mac_en;
  logic signed [DATA_W-1:0]  mac_res;

  logic signed [DATA_W:0]    rec_ext;
  logic signed [DATA_W:0]    rec_b;
  logic signed [DATA_W-2:0]  q4;
  logic signed [PV_W-1:0]    mp_t;
  logic signed [PV_W-1:0]    q4_t;
  logic signed [PV_W-1:0]    nc_t;
  logic signed [PV_W-1:0]    pv;
  logic [PV_W-2-FRAC_BITS:0] pint;
  logic [PRIO_W-1:0]         prio_calc;

  // Handshakes
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // Config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_MAX_PRIO);
  assign prdata  = (reg_idx == REG_MAX_PRIO) ? DATA_W'(max_prio_r) : '0;

  // Effective ready count: saturated, plus the running thread
  always_comb begin
    ready_eff = (in_ready_count > READY_W'(MAX_THREADS)) ? READY_W'(MAX_THREADS)
                                                          : in_ready_count;
    ready_eff = ready_eff + READY_W'(!in_is_idle);
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode_t'(in_mode) == MODE_LOAD) begin
            state_nxt = ST_MUL;
            op_nxt    = OP_LOAD;
          end else if (in_is_idle) begin
            state_nxt = ST_MUL;
            op_nxt    = OP_LX100;
          end else begin
            case (mode_t'(in_mode))
              MODE_DECAY: state_nxt = ST_DIV;
              MODE_PRIO:  state_nxt = ST_PRIO;
              default: begin
                state_nxt = ST_MUL;
                op_nxt    = OP_TICK;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
          op_nxt    = OP_DECAY;
        end
      end
      ST_MUL: state_nxt = ST_POST;
      ST_POST: begin
        case (op_r)
          OP_LX100: begin
            state_nxt = ST_MUL;
            op_nxt    = OP_RX100;
          end
          OP_RX100: state_nxt = ST_DONE;
          default: begin
            state_nxt = ST_MUL;
            op_nxt    = OP_LX100;
          end
        endcase
      end
      ST_PRIO: begin
        state_nxt = ST_MUL;
        op_nxt    = OP_LX100;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: unit controls
  always_comb begin
    div_start      = in_acc && (mode_t'(in_mode) == MODE_DECAY) && !in_is_idle;
    div_num        = {load_r[DATA_W-2:0], 1'b0};
    mac_en         = (state_r == ST_MUL);
    mac_req.a      = recent_r;
    mac_req.b      = MUL_B_W'(SCALE100);
    mac_req.rnd    = 1'b0;
    mac_req.addend = '0;
    case (op_r)
      OP_LOAD: begin
        mac_req.a      = load_r;
        mac_req.b      = MUL_B_W'(K1);
        mac_req.addend = $signed(ADD_W'(K2) * ADD_W'(ready_r));
      end
      OP_DECAY: begin
        mac_req.b      = $signed(MUL_B_W'(div_quot));
        mac_req.addend = ADD_W'(nice_r) <<< FRAC_BITS;
      end
      OP_TICK: begin
        mac_req.b      = MUL_B_W'(FIX_ONE);
        mac_req.addend = ADD_W'(FIX_ONE);
      end
      OP_LX100: begin
        mac_req.a = load_r;
      end
      OP_RX100: begin
        mac_req.rnd = 1'b1;
      end
      default: mac_req.a = recent_r;
    endcase
  end

  // Priority: max*f - trunc(recent/4) - 2*nice*f, truncated and clamped
  always_comb begin
    rec_ext = {recent_r[DATA_W-1], recent_r};
    rec_b   = recent_r[DATA_W-1] ? (rec_ext + (DATA_W+1)'(3)) : rec_ext;
    q4      = rec_b[DATA_W:2];
    mp_t    = PV_W'(max_prio_r) << FRAC_BITS;
    q4_t    = PV_W'(q4);
    nc_t    = PV_W'(nice_r) <<< (FRAC_BITS + 1);
    pv      = mp_t - q4_t - nc_t;
    pint    = pv[PV_W-2:FRAC_BITS];
    if (pv[PV_W-1]) begin
      prio_calc = '0;
    end else if (pint > (PV_W-1-FRAC_BITS)'(max_prio_r)) begin
      prio_calc = max_prio_r;
    end else begin
      prio_calc = pint[PRIO_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_LOAD;
      out_valid_r <= 1'b0;
      max_prio_r  <= PRIO_W'(63);
      load_r      <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        max_prio_r <= pwdata[PRIO_W-1:0];
      end
      if ((state_r == ST_POST) && (op_r == OP_LOAD)) begin
        load_r <= mac_res;
      end
    end
  end

  // Item payload and results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      recent_r <= in_recent_cpu_in;
      nice_r   <= in_nice_value;
      ready_r  <= ready_eff;
      prio_r   <= '0;
    end
    if (state_r == ST_PRIO) begin
      prio_r <= prio_calc;
    end
    if (state_r == ST_POST) begin
      case (op_r)
        OP_DECAY, OP_TICK: recent_r <= mac_res;
        OP_LX100:          lx100_r  <= mac_res;
        OP_RX100:          rx100_r  <= mac_res;
        default:           ;
      endcase
    end
    if (out_load) begin
      out_recent_r <= recent_r;
      out_prio_r   <= prio_r;
      out_lx100_r  <= lx100_r;
      out_rx100_r  <= rx100_r;
    end
  end

  assign out_recent_cpu_out = out_recent_r;
  assign out_priority_out   = out_prio_r;
  assign out_load_x100      = out_lx100_r;
  assign out_recent_x100    = out_rx100_r;

  mlfq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot)
  );

  mlfq_mac u_mac (
    .clk     (clk),
    .load_en (mac_en),
    .req     (mac_req),
    .res     (mac_res)
  );

endmodule
`default_nettype wire
